[sv/rc6_pkg.sv]
// Shared types and constants for the RC6 block cipher.
// No dependencies.
`timescale 1ns / 1ps
package rc6_pkg;
    localparam logic [31:0] P32 = 32'hB7E15163;
    localparam logic [31:0] Q32 = 32'h9E3779B9;
    localparam int KEY_WORDS = 8;

    typedef enum logic [1:0] {
        OP_ENC = 2'd0,
        OP_DEC = 2'd1,
        OP_EXP = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_IDLE = 3'd0,
        CMD_LOAD = 3'd1,
        CMD_INIT = 3'd2,
        CMD_MIX  = 3'd3,
        CMD_ROUND = 3'd4,
        CMD_FINAL = 3'd5,
        CMD_OUT  = 3'd6
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic       dec;
        logic [6:0] kidx;
        logic [6:0] ridx;
        logic [2:0] lidx;
    } t_ctl;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction
endpackage

[sv/rc6_block_cipher.sv]
// RC6-32 block cipher, top level: APB key registers, controller, datapath.
// One item in flight; a waiting result sits in the output register, so the next item
// is taken as it is captured.
// Reset: synchronous active-low; key_length 16, key bytes 0, round keys undefined.
`timescale 1ns / 1ps
module rc6_block_cipher #(
    parameter int ROUNDS = 20,
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_word_a,
    input  logic [31:0] i_word_b,
    input  logic [31:0] i_word_c,
    input  logic [31:0] i_word_d,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_a,
    output logic [31:0] o_out_b,
    output logic [31:0] o_out_c,
    output logic [31:0] o_out_d
);
    import rc6_pkg::*;
    localparam int NKEYS = 2*ROUNDS + 4;

    logic [5:0]  r_key_length;
    logic [63:0] r_key [4];
    logic [255:0] key_flat;
    logic [5:0] klen;
    logic zero;
    logic [31:0] a, b, c, d;
    t_ctl ctl;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 6'd16;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[5:3] == 3'd0) r_key_length <= pwdata[5:0];
            else if (paddr[5:3] <= 3'd4) r_key[2'(paddr[5:3] - 3'd1)] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[5:3] == 3'd0) prdata = {58'd0, r_key_length};
        else if (paddr[5:3] <= 3'd4) prdata = r_key[2'(paddr[5:3] - 3'd1)];
    end

    assign key_flat = {r_key[3], r_key[2], r_key[1], r_key[0]};
    assign klen = (r_key_length > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : r_key_length;

    rc6_ctrl #(.ROUNDS(ROUNDS), .NKEYS(NKEYS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_op(i_op),
        .i_key_length(klen), .i_out_stall(i_stall), .o_in_stall(o_stall),
        .o_out_valid(o_valid), .o_zero(zero), .o_ctl(ctl)
    );

    rc6_datapath #(.NKEYS(NKEYS), .KB(32)) u_dp (
        .i_clk(i_clk), .i_ctl(ctl), .i_key_length(klen), .i_key(key_flat),
        .i_a(i_word_a), .i_b(i_word_b), .i_c(i_word_c), .i_d(i_word_d),
        .o_a(a), .o_b(b), .o_c(c), .o_d(d)
    );

    assign o_out_a = zero ? '0 : a;
    assign o_out_b = zero ? '0 : b;
    assign o_out_c = zero ? '0 : c;
    assign o_out_d = zero ? '0 : d;
endmodule

[sv/rc6_datapath.sv]
// Datapath of the RC6 cipher: round-key memory, key words, block registers.
// Depends on rc6_pkg.
`timescale 1ns / 1ps
module rc6_datapath #(
    parameter int NKEYS = 44,
    parameter int KB = 32
) (
    input  logic              i_clk,
    input  rc6_pkg::t_ctl     i_ctl,
    input  logic [5:0]        i_key_length,
    input  logic [255:0]      i_key,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    input  logic [31:0]       i_c,
    input  logic [31:0]       i_d,
    output logic [31:0]       o_a,
    output logic [31:0]       o_b,
    output logic [31:0]       o_c,
    output logic [31:0]       o_d
);
    import rc6_pkg::*;
    localparam int KW = $clog2(NKEYS);

    logic [31:0] r_s [NKEYS];
    logic [31:0] r_l [KEY_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_ka, r_kb, r_prev, r_srd, r_srd2;
    logic [31:0] r_oa, r_ob, r_oc, r_od;
    logic [31:0] t, u, bb, dd, mix_a, mix_b;
    logic [31:0] s_wr;
    logic [KW-1:0] rd1, rd2;
    logic [7:0]  kbyte [KB];

    always_comb begin
        for (int i = 0; i < KB; i++) begin
            kbyte[i] = (6'(i) < i_key_length) ? i_key[8*i +: 8] : 8'h00;
        end
    end

    assign rd1 = i_ctl.ridx[KW-1:0];
    assign rd2 = (rd1 == KW'(NKEYS-1)) ? '0 : rd1 + 1'b1;

    always_ff @(posedge i_clk) begin
        r_srd  <= r_s[rd1];
        r_srd2 <= r_s[rd2];
    end

    assign mix_a = rotl(r_srd + r_ka + r_kb, 5'd3);
    assign mix_b = rotl(r_l[i_ctl.lidx] + mix_a + r_kb, 5'(mix_a + r_kb));
    assign s_wr  = (i_ctl.kidx == 7'd0) ? P32 : r_prev + Q32;

    function automatic logic [31:0] fmix(input logic [31:0] x);
        logic [31:0] p;
        p = x * {x[30:0], 1'b1};
        return rotl(p, 5'd5);
    endfunction

    assign bb = i_ctl.dec ? r_a : r_b;
    assign dd = i_ctl.dec ? r_c : r_d;
    assign t = fmix(bb);
    assign u = fmix(dd);

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_LOAD: begin
                r_a <= i_a; r_b <= i_b; r_c <= i_c; r_d <= i_d;
                r_ka <= '0; r_kb <= '0;
                for (int i = 0; i < KEY_WORDS; i++) begin
                    r_l[i] <= {kbyte[4*i+3], kbyte[4*i+2], kbyte[4*i+1], kbyte[4*i]};
                end
            end
            CMD_INIT: begin
                r_s[i_ctl.kidx[KW-1:0]] <= s_wr;
                r_prev <= s_wr;
            end
            CMD_MIX: begin
                r_s[i_ctl.kidx[KW-1:0]] <= mix_a;
                r_l[i_ctl.lidx] <= mix_b;
                r_ka <= mix_a;
                r_kb <= mix_b;
            end
            CMD_ROUND: begin
                if (i_ctl.kidx == 7'd0) begin
                    if (i_ctl.dec) begin
                        r_d <= r_d - r_srd2; r_b <= r_b - r_srd;
                    end else begin
                        r_b <= r_b + r_srd; r_d <= r_d + r_srd2;
                    end
                end else if (!i_ctl.dec) begin
                    r_a <= r_b; r_c <= r_d;
                    r_d <= rotl(r_a ^ t, u[4:0]) + r_srd;
                    r_b <= rotl(r_c ^ u, t[4:0]) + r_srd2;
                end else begin
                    r_b <= r_a; r_d <= r_c;
                    r_a <= rotr(r_d - r_srd, u[4:0]) ^ t;
                    r_c <= rotr(r_b - r_srd2, t[4:0]) ^ u;
                end
            end
            CMD_FINAL: begin
                if (i_ctl.dec) begin
                    r_c <= r_c - r_srd2; r_a <= r_a - r_srd;
                end else begin
                    r_a <= r_a + r_srd; r_c <= r_c + r_srd2;
                end
            end
            CMD_OUT: begin
                r_oa <= r_a; r_ob <= r_b; r_oc <= r_c; r_od <= r_d;
            end
            default: begin
            end
        endcase
    end

    assign o_a = r_oa;
    assign o_b = r_ob;
    assign o_c = r_oc;
    assign o_d = r_od;
endmodule

[sv/rc6_ctrl.sv]
// Sequencer for the RC6 cipher: walks loads, key schedule and rounds.
// Depends on rc6_pkg.
`timescale 1ns / 1ps
module rc6_ctrl #(
    parameter int ROUNDS = 20,
    parameter int NKEYS = 44
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_op,
    input  logic [5:0]    i_key_length,
    input  logic          i_out_stall,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output logic          o_zero,
    output rc6_pkg::t_ctl o_ctl
);
    import rc6_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_INIT  = 6'b000010,
        S_MIX   = 6'b000100,
        S_ROUND = 6'b001000,
        S_FINAL = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [6:0] r_k, n_k;
    logic [2:0] r_j, n_j;
    logic [7:0] r_s, n_s;
    logic r_dec, n_dec, r_zero, n_zero;
    logic r_ovalid, n_ovalid, r_ozero, n_ozero;
    logic [5:0] nb;
    logic [3:0] c;
    logic [7:0] steps;

    assign nb = (i_key_length > 6'd32) ? 6'd32 : i_key_length;
    always_comb begin
        c = 4'((nb + 6'd3) >> 2);
        if (c == 4'd0) c = 4'd1;
        steps = ({4'd0, c} > 8'(NKEYS)) ? {4'd0, c} * 8'd3 : 8'(3 * NKEYS);
    end

    always_comb begin
        n_state = r_state; n_k = r_k; n_j = r_j; n_s = r_s;
        n_dec = r_dec; n_zero = r_zero;
        n_ovalid = r_ovalid && i_out_stall;
        n_ozero = r_ozero;
        o_ctl.cmd = CMD_IDLE;
        o_ctl.dec = r_dec;
        o_ctl.kidx = r_k;
        o_ctl.lidx = r_j;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_dec = (i_op == OP_DEC);
                    n_zero = (i_op[1] == 1'b1);
                    n_k = '0; n_j = '0; n_s = '0;
                    if (i_op == OP_EXP) n_state = S_INIT;
                    else if (i_op == OP_NOP) n_state = S_DONE;
                    else begin
                        n_state = S_ROUND;
                        n_k = (i_op == OP_DEC) ? 7'(2*ROUNDS+2) : 7'd0;
                    end
                end
            end
            S_INIT: begin
                o_ctl.cmd = CMD_INIT;
                if (r_k == 7'(NKEYS-1)) begin
                    n_k = '0; n_state = S_MIX;
                end else n_k = r_k + 7'd1;
            end
            S_MIX: begin
                o_ctl.cmd = CMD_MIX;
                n_k = (r_k == 7'(NKEYS-1)) ? 7'd0 : r_k + 7'd1;
                n_j = ({1'b0, r_j} == c - 4'd1) ? 3'd0 : r_j + 3'd1;
                n_s = r_s + 8'd1;
                if (r_s == steps - 8'd1) n_state = S_DONE;
            end
            S_ROUND: begin
                o_ctl.cmd = r_dec && r_k == 7'(2*ROUNDS+2) ? CMD_FINAL : CMD_ROUND;
                if (!r_dec) begin
                    if (r_k == 7'(2*ROUNDS)) n_state = S_FINAL;
                    n_k = r_k + 7'd2;
                end else begin
                    if (r_k == 7'd2) begin
                        n_state = S_FINAL; n_k = 7'd0;
                    end else n_k = r_k - 7'd2;
                end
            end
            S_FINAL: begin
                o_ctl.cmd = r_dec ? CMD_ROUND : CMD_FINAL;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_ctl.cmd = CMD_OUT;
                    n_ovalid = 1'b1;
                    n_ozero = r_zero;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_ctl.ridx = n_k;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_zero = r_ozero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dec <= 1'b0;
            r_zero <= 1'b0;
            r_ovalid <= 1'b0;
            r_ozero <= 1'b0;
            r_k <= '0; r_j <= '0; r_s <= '0;
        end else begin
            r_state <= n_state; r_k <= n_k; r_j <= n_j; r_s <= n_s;
            r_dec <= n_dec; r_zero <= n_zero;
            r_ovalid <= n_ovalid; r_ozero <= n_ozero;
        end
    end
endmodule
